// ----- rtl/mcb_pkg.sv -----
// Shared constants and types for the masked color blend block.
package mcb_pkg;

    // Palette store geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    // Column and row counter width
    localparam int COORD_BITS  = 16;

    // Window register width and the signed width used for edge compares
    localparam int WIN_BITS    = 16;
    localparam int CMP_BITS    = WIN_BITS + 2;

    // Channel width and the largest channel value, used as the blend clamp
    localparam int CH_BITS     = 8;
    localparam int ALPHA_MAX   = 255;

    // Configuration register indexes
    localparam logic [2:0] CFG_SRC_FMT   = 3'd0;
    localparam logic [2:0] CFG_MASK_MODE = 3'd1;
    localparam logic [2:0] CFG_FILL      = 3'd2;
    localparam logic [2:0] CFG_WIN_LEFT  = 3'd3;
    localparam logic [2:0] CFG_WIN_TOP   = 3'd4;
    localparam logic [2:0] CFG_WIN_W     = 3'd5;
    localparam logic [2:0] CFG_WIN_H     = 3'd6;

    // Item commands
    localparam logic CMD_PAL_WR = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    // Mask modes
    localparam logic MODE_ALPHA  = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    // Source pixel formats; code 7 is handled as truecolor
    typedef enum logic [2:0] {
        FMT_TRUE  = 3'd0,
        FMT_IDX8  = 3'd1,
        FMT_GRAY8 = 3'd2,
        FMT_IDX4  = 3'd3,
        FMT_GRAY4 = 3'd4,
        FMT_IDX1  = 3'd5,
        FMT_GRAY1 = 3'd6
    } t_src_fmt;

    // Pixel as three channels: [0] blue, [1] green, [2] red
    typedef logic [2:0][CH_BITS-1:0] t_rgb;

endpackage

// ----- rtl/masked_color_blend.sv -----
// Masked solid color blend: palette expansion, window clip and blend pipeline.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------------
//  in      | input     | i_valid / o_stall | command, palette write, pixel, mask, marks
//  out     | output    | o_valid / i_stall | blue, green, red, in_window, marks
//  cfg     | input     | i_cfg_we          | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled. A pixel reaches the output
// register through palette memory read and window compare, channel multiply, divide by 255
// and clamp. The palette memory's single registered read port sets the first stage.
// Palette write beats produce no output beat. Reset clears counters, config and valids;
// the palette is undefined until written. A stalled output backs the pipeline up stage
// by stage; bubbles are squeezed out before the input side stalls.
module masked_color_blend
    import mcb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config port
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [7:0]          i_palette_index,
    input  logic [23:0]         i_palette_color,
    input  logic [23:0]         i_pixel_value,
    input  logic [7:0]          i_mask_value,
    input  logic                i_row_end,
    input  logic                i_frame_end,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_blue,
    output logic [7:0]          o_out_green,
    output logic [7:0]          o_out_red,
    output logic                o_in_window,
    output logic                o_out_row_end,
    output logic                o_out_frame_end
);

    // ---------------- configuration registers ----------------
    logic [2:0]          r_src_fmt;
    logic                r_mask_mode;
    logic [23:0]         r_fill;
    logic [WIN_BITS-1:0] r_win_left;
    logic [WIN_BITS-1:0] r_win_top;
    logic [WIN_BITS-1:0] r_win_w;
    logic [WIN_BITS-1:0] r_win_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt   <= '0;
            r_mask_mode <= MODE_ALPHA;
            r_fill      <= '0;
            r_win_left  <= '0;
            r_win_top   <= '0;
            r_win_w     <= '0;
            r_win_h     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_FMT:   r_src_fmt   <= i_cfg_data[2:0];
                CFG_MASK_MODE: r_mask_mode <= i_cfg_data[0];
                CFG_FILL:      r_fill      <= i_cfg_data;
                CFG_WIN_LEFT:  r_win_left  <= i_cfg_data[WIN_BITS-1:0];
                CFG_WIN_TOP:   r_win_top   <= i_cfg_data[WIN_BITS-1:0];
                CFG_WIN_W:     r_win_w     <= i_cfg_data[WIN_BITS-1:0];
                CFG_WIN_H:     r_win_h     <= i_cfg_data[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic r_s1_v, r_s2_v, r_o_v;
    logic out_rdy, s2_rdy, s1_rdy;
    logic in_acc, pix_acc, pal_acc;

    assign out_rdy = !r_o_v || !i_stall;
    assign s2_rdy  = !r_s2_v || out_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign o_stall = !s1_rdy;
    assign in_acc  = i_valid && s1_rdy;
    assign pix_acc = in_acc && (i_command == CMD_PIXEL);
    assign pal_acc = in_acc && (i_command == CMD_PAL_WR);

    // ---------------- stage 0: palette address, window compare, counters ----------------
    logic [COORD_BITS-1:0] r_col, r_row;
    logic [7:0]            rd_idx;
    logic                  rd_oob;
    logic                  wr_ok;
    logic                  in_x, in_y;
    logic signed [CMP_BITS-1:0] cx, cy, lx, ty, rx, by;

    // palette index in use for the current format
    always_comb begin
        unique case (t_src_fmt'(r_src_fmt))
            FMT_IDX8: rd_idx = i_pixel_value[7:0];
            FMT_IDX4: rd_idx = {4'b0, i_pixel_value[3:0]};
            FMT_IDX1: rd_idx = {7'b0, i_pixel_value[0]};
            default:  rd_idx = '0;
        endcase
    end

    assign rd_oob = {1'b0, rd_idx} >= 9'(PAL_ENTRIES);
    assign wr_ok  = {1'b0, i_palette_index} < 9'(PAL_ENTRIES);

    // signed window edges: left <= x < left + width, same for rows
    assign cx = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, r_col});
    assign cy = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, r_row});
    assign lx = $signed({{(CMP_BITS-WIN_BITS){r_win_left[WIN_BITS-1]}}, r_win_left});
    assign ty = $signed({{(CMP_BITS-WIN_BITS){r_win_top[WIN_BITS-1]}}, r_win_top});
    assign rx = lx + $signed({{(CMP_BITS-WIN_BITS){1'b0}}, r_win_w});
    assign by = ty + $signed({{(CMP_BITS-WIN_BITS){1'b0}}, r_win_h});
    assign in_x = (cx >= lx) && (cx < rx);
    assign in_y = (cy >= ty) && (cy < by);

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            priority if (i_frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_row_end) begin
                r_col <= '0;
                r_row <= r_row + COORD_BITS'(1);
            end else begin
                r_col <= r_col + COORD_BITS'(1);
            end
        end
    end

    // palette memory, written by palette beats, read for pixel beats
    logic [23:0] mem_pal [PAL_ENTRIES];
    logic [23:0] r_pal_rd;

    always_ff @(posedge i_clk) begin
        if (pal_acc && wr_ok) begin
            mem_pal[i_palette_index[PAL_AW-1:0]] <= i_palette_color;
        end
        if (pix_acc) begin
            r_pal_rd <= mem_pal[rd_idx[PAL_AW-1:0]];
        end
    end

    // stage 1 registers
    logic [23:0] r_s1_pv;
    logic [7:0]  r_s1_mask;
    logic        r_s1_in, r_s1_oob, r_s1_re, r_s1_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_v <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_pv   <= i_pixel_value;
            r_s1_mask <= i_mask_value;
            r_s1_in   <= in_x && in_y;
            r_s1_oob  <= rd_oob;
            r_s1_re   <= i_row_end;
            r_s1_fe   <= i_frame_end;
        end
    end

    // ---------------- stage 1: expand pixel, multiply mask by difference ----------------
    t_rgb pix1, fill_c;
    logic signed [17:0] prod [3];
    logic [7:0] gray;

    assign fill_c = t_rgb'(r_fill);

    always_comb begin
        unique case (t_src_fmt'(r_src_fmt))
            FMT_GRAY4: gray = {r_s1_pv[3:0], r_s1_pv[3:0]};
            FMT_GRAY1: gray = {7'b0, r_s1_pv[0]};
            default:   gray = r_s1_pv[7:0];
        endcase
        unique case (t_src_fmt'(r_src_fmt))
            FMT_IDX8, FMT_IDX4, FMT_IDX1:
                pix1 = r_s1_oob ? t_rgb'(24'h0) : t_rgb'(r_pal_rd);
            FMT_GRAY8, FMT_GRAY4, FMT_GRAY1:
                pix1 = {gray, gray, gray};
            default:
                pix1 = t_rgb'(r_s1_pv);
        endcase
    end

    for (genvar c = 0; c < 3; c++) begin : g_mul
        logic signed [8:0] diff;
        assign diff    = $signed({1'b0, fill_c[c]}) - $signed({1'b0, pix1[c]});
        assign prod[c] = 18'($signed({1'b0, r_s1_mask})) * 18'(diff);
    end

    // stage 2 registers
    logic signed [17:0] r_s2_prod [3];
    t_rgb               r_s2_pix;
    logic               r_s2_mnz, r_s2_in, r_s2_re, r_s2_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_v) begin
            r_s2_prod <= prod;
            r_s2_pix  <= pix1;
            r_s2_mnz  <= r_s1_mask != 8'h00;
            r_s2_in   <= r_s1_in;
            r_s2_re   <= r_s1_re;
            r_s2_fe   <= r_s1_fe;
        end
    end

    // ---------------- stage 2: divide by 255 toward zero, add, clamp, select by mode ----------------
    t_rgb blend, res;

    for (genvar c = 0; c < 3; c++) begin : g_div
        logic               neg;
        logic [15:0]        mag;
        logic [16:0]        acc;
        logic [7:0]         quo;
        logic signed [9:0]  sum;

        assign neg = r_s2_prod[c][17];
        assign mag = neg ? 16'(-r_s2_prod[c]) : 16'(r_s2_prod[c]);
        // floor(x / 255) for x below 65280, where the quotient fits in 8 bits
        assign acc = 17'(mag) + 17'(mag[15:8]) + 17'd1;
        assign quo = acc[15:8];
        assign sum = $signed({2'b0, r_s2_pix[c]})
                   + (neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));

        always_comb begin
            priority if (sum < 0) begin
                blend[c] = '0;
            end else if (sum > 10'sd255) begin
                blend[c] = 8'(ALPHA_MAX);
            end else begin
                blend[c] = sum[7:0];
            end
        end
    end

    always_comb begin
        res = r_s2_pix;
        if (r_s2_in) begin
            if (r_mask_mode == MODE_BINARY) begin
                if (r_s2_mnz) begin
                    res = fill_c;
                end
            end else begin
                res = blend;
            end
        end
    end

    // output register
    t_rgb r_o_rgb;
    logic r_o_in, r_o_re, r_o_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_rdy) begin
            r_o_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_s2_v) begin
            r_o_rgb <= res;
            r_o_in  <= r_s2_in;
            r_o_re  <= r_s2_re;
            r_o_fe  <= r_s2_fe;
        end
    end

    assign o_valid         = r_o_v;
    assign o_out_blue      = r_o_rgb[0];
    assign o_out_green     = r_o_rgb[1];
    assign o_out_red       = r_o_rgb[2];
    assign o_in_window     = r_o_in;
    assign o_out_row_end   = r_o_re;
    assign o_out_frame_end = r_o_fe;

endmodule
